>>> src/spff_pkg.sv
// ============================================================================
// Slot pool package
// Shared constants, item types and cell interface structs for the first-free
// slot pool and its row of slot cells.
// ============================================================================
package spff_pkg;

    localparam int SLOTS      = 16;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CFG_W      = 5;
    localparam int CMP_W      = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
    localparam int SLOT_OUT_W = 4;

    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = CFG_W'(16);

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  client;
        logic [7:0]  proxy;
        logic [7:0]  server;
        logic [7:0]  status;
    } t_record;

    typedef struct packed {
        logic        req_type;
        logic [15:0] op_id;
        logic [7:0]  op_client;
        logic [7:0]  op_proxy;
        logic [7:0]  op_server;
        logic [7:0]  op_status;
    } t_req_item;

    typedef struct packed {
        logic                  done_res;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [15:0]           out_id;
        logic [7:0]            out_client;
        logic [7:0]            out_proxy;
        logic [7:0]            out_server;
        logic [7:0]            out_status;
    } t_rsp_item;

    // Request broadcast to every cell while a search runs.
    typedef struct packed {
        logic    hold;
        logic    want_occ;
        t_record wrec;
    } t_cell_bus;

    // What a cell reports about the search token it holds.
    typedef struct packed {
        logic tok;
        logic hit;
        logic stop;
        logic pass;
    } t_cell_ctl;

endpackage

>>> src/spff_cell.sv
// ============================================================================
// Slot cell
// One slot of the pool: occupied bit, stored record and the search token
// that walks the row one cell per cycle while the row is not held.
// ============================================================================
module spff_cell
    import spff_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [CFG_W-1:0] i_limit,
    input  t_cell_bus        i_bus,
    input  logic             i_tok,
    output t_cell_ctl        o_ctl,
    output t_record          o_rec
);

    logic    r_tok;
    logic    r_occ;
    t_record r_rec;
    logic    in_range;
    logic    match;

    assign in_range = CMP_W'(i_idx) < CMP_W'(i_limit);
    assign match    = (r_occ == i_bus.want_occ);

    assign o_ctl.tok  = r_tok;
    assign o_ctl.hit  = r_tok & in_range & match;
    assign o_ctl.stop = r_tok & ~in_range;
    assign o_ctl.pass = r_tok & in_range & ~match;
    assign o_rec      = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
            r_occ <= 1'b0;
        end else if (!i_bus.hold) begin
            r_tok <= i_tok;
            if (o_ctl.hit) begin
                r_occ <= ~i_bus.want_occ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_bus.hold && o_ctl.hit && !i_bus.want_occ) begin
            r_rec <= i_bus.wrec;
        end
    end

endmodule

>>> src/slot_pool_first_free.sv
// ============================================================================
// Slot pool with first-free allocation
// Write stores a record in the lowest free slot; read returns and frees the
// lowest occupied slot.
// ============================================================================
// A request is answered by a token that walks the row of slot cells from slot
// zero, one cell per clock while the row is not held, until it meets a slot of
// the wanted kind, leaves the slots in use or runs off the end of the row. The
// next item can be accepted once the search has ended, whether a slot answers,
// the token leaves the slots in use or it runs off the end of the row. One item
// is in the row at a time; the result sits in an output register, and the next
// item is taken while it waits unless a finished search is held behind it, in
// which case the row stands still until the waiting result is taken.
module slot_pool_first_free
    import spff_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_req_item        i_item,
    output logic             o_stall,
    output logic             o_valid,
    output t_rsp_item        o_item,
    input  logic             i_stall,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    logic             r_busy;
    logic             r_out_valid;
    logic [CFG_W-1:0] r_slots_in_use;
    t_req_item        r_req;
    t_rsp_item        r_out;
    t_rsp_item        n_out;

    t_cell_bus        bus;
    t_cell_ctl        ctl [SLOTS];
    t_record          rec [SLOTS];
    logic [SLOTS-1:0] tok_in;
    logic [SLOTS-1:0] tok_vec;
    logic [SLOTS-1:0] hit_vec;
    logic [SLOTS-1:0] stop_vec;
    logic             hold;
    logic             accept;
    logic             done;
    logic             hit_any;
    logic [IDX_W-1:0] idx_sel;
    t_record          rec_sel;

    // The row only stands still when a finished search cannot hand over.
    assign hold    = done & r_out_valid & i_stall;
    assign o_stall = r_busy;
    assign accept  = i_valid & ~o_stall;

    assign bus.hold        = hold;
    assign bus.want_occ    = (r_req.req_type == REQ_READ);
    assign bus.wrec.id     = r_req.op_id;
    assign bus.wrec.client = r_req.op_client;
    assign bus.wrec.proxy  = r_req.op_proxy;
    assign bus.wrec.server = r_req.op_server;
    assign bus.wrec.status = r_req.op_status;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign tok_in[g] = accept;
        end else begin : g_link
            assign tok_in[g] = ctl[g-1].pass;
        end

        spff_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_limit (r_slots_in_use),
            .i_bus   (bus),
            .i_tok   (tok_in[g]),
            .o_ctl   (ctl[g]),
            .o_rec   (rec[g])
        );

        assign tok_vec[g]  = ctl[g].tok;
        assign hit_vec[g]  = ctl[g].hit;
        assign stop_vec[g] = ctl[g].stop;
    end

    assign hit_any = |hit_vec;
    assign done    = hit_any | (|stop_vec) | ctl[SLOTS-1].pass;

    // At most one cell hits, so the hitting cell's index and record are ORed.
    always_comb begin
        idx_sel = '0;
        rec_sel = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (hit_vec[k]) begin
                idx_sel = idx_sel | IDX_W'(k);
                rec_sel = rec_sel | rec[k];
            end
        end
    end

    always_comb begin
        n_out            = '0;
        n_out.done_res   = hit_any;
        n_out.slot_index = SLOT_OUT_W'(idx_sel);
        if (hit_any && r_req.req_type == REQ_READ) begin
            n_out.out_id     = rec_sel.id;
            n_out.out_client = rec_sel.client;
            n_out.out_proxy  = rec_sel.proxy;
            n_out.out_server = rec_sel.server;
            n_out.out_status = rec_sel.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_slots_in_use <= SLOTS_IN_USE_RST;
        end else begin
            if (i_cfg_we) begin
                r_slots_in_use <= i_cfg_wdata;
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done && !hold) begin
                r_busy <= 1'b0;
            end
            if (done && !hold) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_item;
        end
        if (done && !hold) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vec))
        else $error("more than one search token in the cell row");

    a_idle_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (tok_vec == '0))
        else $error("search token present while no item is in progress");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_busy && tok_vec[0]))
        else $error("accepted item did not start a search at slot zero");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.done_res) |-> (o_item.slot_index == '0 && o_item.out_id == '0))
        else $error("result without a slot carries a non-zero index or record");

endmodule
